@@ src/urldec_pkg.sv @@
// ----------------------------------------------------------------------------
// urldec_pkg
// Shared constants, types and character helpers for the URL percent decoder.
// ----------------------------------------------------------------------------
package urldec_pkg;

  localparam int unsigned BYTE_W = 8;

  localparam logic [BYTE_W-1:0] PCT_CHAR   = 8'h25;
  localparam logic [BYTE_W-1:0] PLUS_CHAR  = 8'h2B;
  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

  // Output queue sizing. One input item yields at most MAX_RESULTS items.
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned FIFO_DEPTH  = 8;
  localparam int unsigned PTR_W       = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W       = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned NRES_W      = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } res_t;

  function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] t;
    t = '0;
    if (c inside {[8'h30:8'h39]}) begin
      t = c - 8'h30;
    end else if (c inside {[8'h41:8'h46]}) begin
      t = c - 8'h37;
    end else if (c inside {[8'h61:8'h66]}) begin
      t = c - 8'h57;
    end
    return t[3:0];
  endfunction

  function automatic logic [BYTE_W-1:0] plain(input logic [BYTE_W-1:0] c);
    return (c == PLUS_CHAR) ? SPACE_CHAR : c;
  endfunction

endpackage

@@ src/urldec_ifs.sv @@
// ----------------------------------------------------------------------------
// urldec_ifs
// Valid/ready channels for encoded input bytes and decoded result bytes.
// ----------------------------------------------------------------------------
interface urldec_in_if import urldec_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface urldec_out_if import urldec_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

@@ src/url_percent_decoder_core.sv @@
// ----------------------------------------------------------------------------
// url_percent_decoder_core
// Streaming URL percent decoder: plus to space, %XY escapes to one byte.
// ----------------------------------------------------------------------------
// The block accepts one encoded byte per clock cycle while its input channel
// is ready. Each accepted item is decoded in the same cycle it is taken and
// yields zero to three result items, registered into an 8-entry output queue
// and offered on the output channel behind any older queued results. The
// queue drains one item per cycle while the output side is ready; the input
// channel is ready whenever at least three queue entries are free, so with the
// output side always ready the block sustains one input item per cycle. Up to
// two bytes of an undecided escape are held; after a last item nothing is held.
module url_percent_decoder_core import urldec_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  urldec_in_if.sink        in_ch,
  urldec_out_if.source     out_ch
);

  typedef enum logic [1:0] {
    HOLD_NONE     = 2'd0,
    HOLD_PCT      = 2'd1,
    HOLD_PCT_BYTE = 2'd2
  } hold_t;

  hold_t             hold_r, hold_nxt;
  logic [BYTE_W-1:0] held_r, held_nxt;

  res_t              fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  res_t              res    [MAX_RESULTS];
  logic [NRES_W-1:0] n_res;
  logic              fresh_en;
  logic              in_acc, out_acc;
  logic [BYTE_W-1:0] b;
  logic              lst;

  assign b   = in_ch.in_byte;
  assign lst = in_ch.in_last;

  assign in_ch.ready = (count_r <= CNT_W'(FIFO_DEPTH - MAX_RESULTS));
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign out_ch.valid    = (count_r != '0);
  assign out_ch.out_byte = fifo_r[rd_ptr_r].data;
  assign out_ch.out_last = fifo_r[rd_ptr_r].last;
  assign out_acc         = out_ch.valid && out_ch.ready;

  // Decode: build up to three results from the held bytes and the new byte.
  always_comb begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      res[k] = '{data: '0, last: 1'b0};
    end
    n_res    = '0;
    fresh_en = 1'b0;
    hold_nxt = hold_r;
    held_nxt = held_r;

    case (hold_r)
      HOLD_PCT: begin
        if (lst) begin
          res[0] = '{data: PCT_CHAR, last: 1'b0};
          res[1] = '{data: b, last: 1'b1};
          n_res  = NRES_W'(2);
          hold_nxt = HOLD_NONE;
        end else begin
          held_nxt = b;
          hold_nxt = HOLD_PCT_BYTE;
        end
      end
      HOLD_PCT_BYTE: begin
        if (is_alnum(held_r) && is_alnum(b)) begin
          res[0] = '{data: {hex_val(held_r), hex_val(b)}, last: lst};
          n_res  = NRES_W'(1);
          hold_nxt = HOLD_NONE;
        end else if (held_r == PCT_CHAR) begin
          // The held byte is itself a percent sign and may open a new escape.
          res[0] = '{data: PCT_CHAR, last: 1'b0};
          if (lst) begin
            res[1] = '{data: PCT_CHAR, last: 1'b0};
            res[2] = '{data: b, last: 1'b1};
            n_res  = NRES_W'(3);
            hold_nxt = HOLD_NONE;
          end else begin
            n_res    = NRES_W'(1);
            held_nxt = b;
            hold_nxt = HOLD_PCT_BYTE;
          end
        end else begin
          res[0]   = '{data: PCT_CHAR, last: 1'b0};
          res[1]   = '{data: plain(held_r), last: 1'b0};
          n_res    = NRES_W'(2);
          fresh_en = 1'b1;
        end
      end
      default: begin
        fresh_en = 1'b1;
      end
    endcase

    // The new byte seen with nothing pending, appended after earlier results.
    if (fresh_en) begin
      if (b == PCT_CHAR && !lst) begin
        hold_nxt = HOLD_PCT;
      end else begin
        res[n_res[1:0]] = '{data: plain(b), last: lst};
        n_res    = n_res + NRES_W'(1);
        hold_nxt = HOLD_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r   <= HOLD_NONE;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_acc) begin
        hold_r   <= hold_nxt;
        wr_ptr_r <= wr_ptr_r + PTR_W'(n_res);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + (in_acc ? CNT_W'(n_res) : CNT_W'(0))
                         - (out_acc ? CNT_W'(1) : CNT_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      held_r <= held_nxt;
      for (int k = 0; k < MAX_RESULTS; k++) begin
        if (NRES_W'(k) < n_res) begin
          fifo_r[wr_ptr_r + PTR_W'(k)] <= res[k];
        end
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FIFO_DEPTH))
    else $error("output queue count exceeds its depth");

  a_room_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (count_r <= CNT_W'(FIFO_DEPTH - MAX_RESULTS)))
    else $error("item accepted without room for its results");

  a_last_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && lst) |=> (hold_r == HOLD_NONE))
    else $error("bytes still held after the last item of a string");

  a_last_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && lst) |-> (n_res != '0))
    else $error("last item of a string produced no result");

  a_no_hold_three: assert property (@(posedge clk) disable iff (!rst_n)
    hold_r != hold_t'(2'd3))
    else $error("held count reached an impossible value");

endmodule

@@ bench/urldec_checker.sv @@
// ----------------------------------------------------------------------------
// urldec_checker
// Watches both channels of the URL percent decoder, predicts the decoded
// bytes of every accepted input item and compares each accepted result with
// the oldest prediction, data and last flag separately.
// ----------------------------------------------------------------------------
module urldec_checker import urldec_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  urldec_in_if  in_ch,
  urldec_out_if out_ch,
  output int    fail_count,
  output int    pending
);

  res_t              decoded_q[$];
  res_t              want;
  logic [1:0]        esc_held;
  logic [BYTE_W-1:0] esc_second;
  int                result_idx;

  initial begin
    fail_count = 0;
    pending    = 0;
    result_idx = 0;
    esc_held   = 2'd0;
    esc_second = '0;
  end

  task automatic report_mismatch(input string msg);
    $display("checker: result %0d: %s", result_idx, msg);
    fail_count++;
  endtask

  function automatic logic is_word_char(input logic [BYTE_W-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  // The low nibble of a digit is its value; A-F and a-f sit at 1-6.
  function automatic logic [3:0] nibble_of(input logic [BYTE_W-1:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return c[3:0];
    end
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      return c[3:0] + 4'd9;
    end
    return 4'd0;
  endfunction

  function automatic void queue_result(input logic [BYTE_W-1:0] d, input logic l);
    res_t r;
    r.data = d;
    r.last = l;
    decoded_q.push_back(r);
  endfunction

  // A byte seen with no escape pending.
  function automatic void take_fresh(input logic [BYTE_W-1:0] b, input logic lst);
    if (b == PCT_CHAR && !lst) begin
      esc_held = 2'd1;
    end else begin
      queue_result((b == PLUS_CHAR) ? SPACE_CHAR : b, lst);
      esc_held = 2'd0;
    end
  endfunction

  function automatic void decode_step(input logic [BYTE_W-1:0] b, input logic lst);
    logic [BYTE_W-1:0] a;
    a = esc_second;
    case (esc_held)
      2'd1: begin
        if (lst) begin
          queue_result(PCT_CHAR, 1'b0);
          queue_result(b, 1'b1);
          esc_held = 2'd0;
        end else begin
          esc_second = b;
          esc_held   = 2'd2;
        end
      end
      2'd2: begin
        if (is_word_char(a) && is_word_char(b)) begin
          queue_result({nibble_of(a), nibble_of(b)}, lst);
          esc_held = 2'd0;
        end else begin
          queue_result(PCT_CHAR, 1'b0);
          if (a == PCT_CHAR) begin
            // The second percent sign opens a new escape of its own.
            if (lst) begin
              queue_result(PCT_CHAR, 1'b0);
              queue_result(b, 1'b1);
              esc_held = 2'd0;
            end else begin
              esc_second = b;
              esc_held   = 2'd2;
            end
          end else begin
            queue_result((a == PLUS_CHAR) ? SPACE_CHAR : a, 1'b0);
            take_fresh(b, lst);
          end
        end
      end
      default: begin
        take_fresh(b, lst);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      esc_held = 2'd0;
      decoded_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0b",
                                    out_ch.out_byte, out_ch.out_last));
        end else begin
          want = decoded_q.pop_front();
          if (out_ch.out_byte !== want.data) begin
            report_mismatch($sformatf("byte %02h, predicted %02h",
                                      out_ch.out_byte, want.data));
          end
          if (out_ch.out_last !== want.last) begin
            report_mismatch($sformatf("last %0b, predicted %0b",
                                      out_ch.out_last, want.last));
          end
        end
        result_idx++;
      end
      if (in_ch.valid && in_ch.ready) begin
        decode_step(in_ch.in_byte, in_ch.in_last);
      end
    end
    pending = decoded_q.size();
  end

endmodule

@@ bench/tb_url_percent_decoder_core.sv @@
// ----------------------------------------------------------------------------
// tb_url_percent_decoder_core
// Drives encoded strings into the decoder: a directed set of escapes, plus
// signs and percent signs near the end, then random strings of escapes, plus
// signs and other bytes. Both sides idle at random; the checker beside
// the block predicts and compares every decoded item.
// ----------------------------------------------------------------------------
module tb_url_percent_decoder_core;
  import urldec_pkg::*;

  localparam int ITEM_TARGET  = 500;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_t;

  logic              clk;
  logic              rst_n;
  int                fail_count;
  int                pending;
  int                items_sent;
  int                burst_left;
  int                idle_cycles;
  logic [BYTE_W-1:0] text_q[$];

  urldec_in_if  in_if();
  urldec_out_if out_if();

  url_percent_decoder_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  urldec_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Ends the run when neither channel has moved an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[url_percent_decoder_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        in_if.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    in_if.valid   = 1'b1;
    in_if.in_byte = b;
    in_if.in_last = lst;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_text_q();
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) begin
      text_q.push_back(s[i]);
    end
    send_text_q();
  endtask

  // A random string of escapes, plus signs and other bytes, sometimes cut
  // short by its last byte, which can leave it ending inside an escape.
  function automatic void make_random_text();
    string hexd;
    string alnum;
    int    pieces;
    int    kind;
    hexd   = "0123456789ABCDEFabcdef";
    alnum  = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
    pieces = $urandom_range(1, 6);
    text_q.delete();
    repeat (pieces) begin
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        text_q.push_back(BYTE_W'($urandom_range(1, 255)));
      end else if (kind <= 5) begin
        text_q.push_back(PCT_CHAR);
        text_q.push_back(hexd[$urandom_range(0, 21)]);
        text_q.push_back(hexd[$urandom_range(0, 21)]);
      end else if (kind == 6) begin
        text_q.push_back(PCT_CHAR);
        text_q.push_back(alnum[$urandom_range(0, 61)]);
        text_q.push_back(alnum[$urandom_range(0, 61)]);
      end else if (kind == 7) begin
        text_q.push_back(PLUS_CHAR);
      end else if (kind == 8) begin
        text_q.push_back(PCT_CHAR);
        text_q.push_back(BYTE_W'($urandom_range(1, 255)));
        text_q.push_back(BYTE_W'($urandom_range(1, 255)));
      end else begin
        text_q.push_back(PCT_CHAR);
        if ($urandom_range(0, 1) == 1) begin
          text_q.push_back(PCT_CHAR);
        end
      end
    end
    if (text_q.size() > 2 && $urandom_range(0, 3) == 0) begin
      void'(text_q.pop_back());
    end
  endfunction

  // Output side: a long hold-off early on while input keeps coming, then
  // segments of open, coin-flip, fixed-pattern and sparse ready.
  initial begin
    rx_mode_t   mode;
    int         seg_len;
    logic [4:0] pat;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    out_if.ready = 1'b1;
    repeat (40) @(negedge clk);
    out_if.ready = 1'b0;
    repeat (HOLD_CYCLES) @(negedge clk);
    forever begin
      mode    = rx_mode_t'($urandom_range(0, 3));
      seg_len = $urandom_range(20, 80);
      pat     = 5'($urandom_range(1, 31));
      for (int k = 0; k < seg_len; k++) begin
        case (mode)
          RX_OPEN:    out_if.ready = 1'b1;
          RX_COIN:    out_if.ready = 1'($urandom_range(0, 1));
          RX_PATTERN: out_if.ready = pat[k % 5];
          default:    out_if.ready = ($urandom_range(0, 3) == 0);
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = '0;
    in_if.in_last = 1'b0;
    items_sent    = 0;
    burst_left    = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_text("%41");
    send_text("%00");
    send_text("%fF");
    send_text("%zZ");
    send_text("+");
    send_text("%");
    send_text("%+");
    send_text("%%41");
    send_text("%%%");
    // Bytes above 127 are neither letters nor digits and break an escape.
    text_q = '{8'h01, 8'hFF, PCT_CHAR, 8'hC1, 8'h32};
    send_text_q();

    while (items_sent < ITEM_TARGET) begin
      make_random_text();
      send_text_q();
    end
    in_if.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("[url_percent_decoder_core] OK");
    end else begin
      $display("[url_percent_decoder_core] ERROR");
    end
    $finish;
  end

endmodule

@@ url_percent_decoder_core.f @@
src/urldec_pkg.sv
src/urldec_ifs.sv
src/url_percent_decoder_core.sv
bench/urldec_checker.sv
bench/tb_url_percent_decoder_core.sv
